// ----- rtl/smsrng_pkg.sv -----
`timescale 1ns / 1ps
// constants and types shared by the shuffled minimal standard generator
package smsrng_pkg;

  localparam int unsigned WordW = 31;
  localparam int unsigned MulW  = 15;
  localparam int unsigned ProdW = WordW + MulW;

  localparam logic [MulW-1:0]  MulA = 15'd16807;
  localparam logic [WordW-1:0] ModM = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_FOLD,
    ST_DRAW_MUL,
    ST_DRAW_FOLD,
    ST_DIV,
    ST_READ,
    ST_SWAP
  } rng_state_e;

endpackage

// ----- rtl/smsrng_mulmod.sv -----
`timescale 1ns / 1ps
// shared multiply by 16807 and fold modulo 2^31-1, product registered before the fold
module smsrng_mulmod import smsrng_pkg::*; (
  input  logic             clk_i,
  input  logic             load_i,
  input  logic [WordW-1:0] x_i,
  output logic [WordW-1:0] y_o
);

  logic [ProdW-1:0] prod_q;
  logic [WordW:0]   sum;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= ProdW'(x_i) * ProdW'(MulA);
    end
  end

  // 2^31 == 1 mod m, so high part folds onto low part
  assign sum = {1'b0, prod_q[WordW-1:0]} + (WordW + 1)'(prod_q[ProdW-1:WordW]);
  assign y_o = (sum >= {1'b0, ModM}) ? WordW'(sum - {1'b0, ModM}) : sum[WordW-1:0];

endmodule

// ----- rtl/shuffled_minimal_standard_rng.sv -----
`timescale 1ns / 1ps
// shuffled minimal standard random word generator, top level
//
// Each beat taken on s_axis requests one random word, returned on m_axis.
// s_axis_tdata[0] is the reseed flag; m_axis_tdata[30:0] is the word, and
// the uniform deviate is that word divided by 2^31-1.
// The user must write the seed register through cfg_wr_en_i / cfg_wr_data_i while
// idle; the block itself does not enforce this. One request is in flight at a time;
// s_axis_tready is high only when idle. A draw goes from accept to m_axis_tvalid
// through the shared multiply-fold unit, then forms the table index by constant
// reciprocal multiplication, then does the registered table read and the swap.
// Seeding, on reseed or when the last word is zero, comes first and runs
// TABLE_DEPTH+8 warm-up steps, each of which passes the multiply-fold unit.
// The first request after reset always seeds.
// Reset sets the seed to -1 and clears generator and last word; the table
// holds nothing until seeding fills it.
// A finished word waits in the output register while m_axis_tready is low;
// the next request is accepted but its word is held back until that beat is taken.
module shuffled_minimal_standard_rng import smsrng_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [31:0] cfg_wr_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] reseed, [7:1] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [30:0] random_word, [31] zero
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 8);
  localparam int QW = 7;
  localparam int PW = WordW + 32;
  localparam logic [31:0] Bucket = 32'd1 + 32'd2147483646 / 32'(TABLE_DEPTH);
  localparam int BucketW = $clog2(Bucket);
  localparam int RecipSh = WordW + BucketW;
  localparam logic [63:0] RecipWide =
      ((64'd1 << RecipSh) + 64'(Bucket) - 64'd1) / 64'(Bucket);
  localparam logic [31:0] Recip = RecipWide[31:0];

  rng_state_e state_q, state_d;

  logic [31:0]      seed_q;
  logic [WordW-1:0] gen_q, gen_d;
  logic [WordW-1:0] last_q, last_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]    quo_q, quo_d;
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] out_data_q;
  logic             out_load;

  logic [WordW-1:0] mem_q [TABLE_DEPTH];
  logic [WordW-1:0] rd_q;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [WordW-1:0] mem_wdata;
  logic             mem_re;

  logic             mul_load;
  logic [WordW-1:0] mul_y;
  logic [31:0]      seed_mag;
  logic [WordW-1:0] start_val;
  logic             in_acc;
  logic [PW-1:0]    idx_prod;
  logic [QW-1:0]    idx_raw;
  logic [AW-1:0]    slot;

  smsrng_mulmod u_mulmod (
    .clk_i  (clk_i),
    .load_i (mul_load),
    .x_i    (gen_q),
    .y_o    (mul_y)
  );

  assign seed_mag  = 32'd0 - seed_q;
  assign start_val = !seed_q[31] ? WordW'(1) :
                     (seed_mag >= {1'b0, ModM}) ? WordW'(seed_mag - {1'b0, ModM}) :
                     seed_mag[WordW-1:0];

  // last word divided by the bucket size, clamped to the last entry
  assign idx_prod = PW'(last_q) * PW'(Recip);
  assign idx_raw  = QW'(idx_prod >> RecipSh);
  assign slot     = (idx_raw >= QW'(TABLE_DEPTH)) ? AW'(TABLE_DEPTH - 1) :
                    idx_raw[AW-1:0];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d     = state_q;
    gen_d       = gen_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    quo_d       = quo_q;
    out_valid_d = out_valid_q;
    out_load    = 1'b0;
    mul_load    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = quo_q;
    mem_wdata   = gen_q;
    mem_re      = 1'b0;

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tdata[0] || (last_q == '0)) begin
            gen_d   = start_val;
            cnt_d   = CW'(TABLE_DEPTH + 7);
            state_d = ST_SEED_MUL;
          end else begin
            state_d = ST_DRAW_MUL;
          end
        end
      end
      ST_SEED_MUL: begin
        mul_load = 1'b1;
        state_d  = ST_SEED_FOLD;
      end
      ST_SEED_FOLD: begin
        gen_d = mul_y;
        if (cnt_q < CW'(TABLE_DEPTH)) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_q[AW-1:0];
          mem_wdata = mul_y;
        end
        if (cnt_q == '0) begin
          last_d  = mul_y;
          state_d = ST_DRAW_MUL;
        end else begin
          cnt_d   = cnt_q - 1'b1;
          state_d = ST_SEED_MUL;
        end
      end
      ST_DRAW_MUL: begin
        mul_load = 1'b1;
        state_d  = ST_DRAW_FOLD;
      end
      ST_DRAW_FOLD: begin
        gen_d   = mul_y;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        quo_d   = slot;
        state_d = ST_READ;
      end
      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_SWAP;
      end
      ST_SWAP: begin
        if (!out_valid_q || m_axis_tready) begin
          last_d      = rd_q;
          mem_we      = 1'b1;
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seed_q      <= '1;
      gen_q       <= '0;
      last_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gen_q       <= gen_d;
      last_q      <= last_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr_en_i) begin
        seed_q <= cfg_wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    if (out_load) begin
      out_data_q <= rd_q;
    end
  end

  // shuffle table
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[quo_q];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_data_q};

endmodule

// ----- rtl/smsrng_checker.sv -----
`timescale 1ns / 1ps
// port-level checks for the shuffled minimal standard generator, with bind
module smsrng_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // one request at a time
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // no word becomes valid right after a request is taken
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("word appeared too early");

  // word stays below 2^31
  a_word_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[31])
    else $error("word out of range");

endmodule

bind shuffled_minimal_standard_rng smsrng_checker u_smsrng_checker (.*);
